/* sv/gelu_pkg.sv */
package gelu_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned FracW = 15;
  localparam int unsigned IdxW = $clog2(TableEntries + 1);
  localparam int unsigned PosW = FracW + IdxW;
  localparam int unsigned RomW = 16;
  localparam int unsigned RomBits = (TableEntries + 1) * RomW;
  localparam int unsigned MagW = 15;
  localparam int unsigned PhW = 32;
  localparam int unsigned ProdW = PhW + MagW;
  localparam int unsigned RndPos = 31;
  localparam int unsigned SeriesTerms = 64;
  localparam longint unsigned InvSqrt2PiQ32 = 64'd1713444047;
  localparam longint SeriesMax = 64'sd6000000000;

  localparam logic signed [15:0] XHigh = 16'sd16384;
  localparam logic signed [15:0] XLow = -16'sd16384;

  typedef enum logic [1:0] {
    ClsTable,
    ClsPass,
    ClsZero
  } gelu_cls_e;

  typedef struct packed {
    logic signed [15:0] x_in;
    logic               last_in;
  } gelu_req_t;

  typedef struct packed {
    logic signed [15:0] y_out;
    logic               last_out;
  } gelu_rsp_t;

  typedef struct packed {
    gelu_cls_e          cls;
    logic               neg;
    logic [MagW-1:0]    mag;
    logic signed [15:0] x;
    logic               last;
  } gelu_ctl_t;

  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    begin
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem = rem - den;
          quo[b] = 1'b1;
        end
      end
      div_u64 = quo;
    end
  endfunction

  function automatic logic [RomW-1:0] phi_sample(input int unsigned i);
    longint unsigned k;
    longint unsigned a;
    longint unsigned term;
    longint unsigned h;
    longint          s;
    bit              neg;
    begin
      neg = (2 * i < TableEntries);
      k = neg ? longint'(TableEntries - 2 * i) : longint'(2 * i - TableEntries);
      a = ((64'd4 * k) << 32) / TableEntries;
      s = 0;
      for (int unsigned j = 0; j < SeriesTerms; j++) begin
        term = div_u64(a, 64'd2 * j + 64'd1);
        if (j[0]) begin
          s = s - longint'(term);
        end else begin
          s = s + longint'(term);
        end
        a = a * k / TableEntries;
        a = a * k / TableEntries;
        a = div_u64(a * 64'd8, j + 64'd1);
      end
      if (s < 0) begin
        s = 0;
      end
      if (s > SeriesMax) begin
        s = SeriesMax;
      end
      h = (longint'(s) * InvSqrt2PiQ32 + (64'd1 << 47)) >> 48;
      if (h > 64'd32767) begin
        h = 64'd32767;
      end
      phi_sample = neg ? RomW'(64'd32768 - h) : RomW'(64'd32768 + h);
    end
  endfunction

  function automatic logic [RomBits-1:0] build_phi_rom();
    logic [RomBits-1:0] rom;
    begin
      rom = '0;
      for (int unsigned i = 0; i <= TableEntries; i++) begin
        rom[RomW*i +: RomW] = phi_sample(i);
      end
      build_phi_rom = rom;
    end
  endfunction

  localparam logic [RomBits-1:0] PhiRom = build_phi_rom();

endpackage

/* sv/gelu_activation_unit.sv */
// GeLU activation, y = x * Phi(x), on signed Q4.12 elements. One request is
// taken per cycle while the output is not stalled, and the five register
// stages are range/index, table read, linear interpolation, scaling multiply,
// and round plus output register. Phi comes from a 257-word Q0.16 table
// built at elaboration and interpolated with a Q15 fraction. Inputs of 4.0
// and above pass through, inputs below -4.0 give zero, and the last flag
// travels with its element.
module gelu_activation_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  gelu_pkg::gelu_req_t req_i,
  output logic                valid_o,
  input  logic                stall_i,
  output gelu_pkg::gelu_rsp_t rsp_o
);

  logic                        idx_valid, idx_ready;
  logic                        ip_valid, ip_ready;
  logic                        in_ready;
  gelu_pkg::gelu_ctl_t         idx_ctl, ip_ctl;
  logic [gelu_pkg::IdxW-1:0]   idx;
  logic [gelu_pkg::FracW-1:0]  frac;
  logic [gelu_pkg::PhW-1:0]    phi;

  assign stall_o = !in_ready;

  gelu_index u_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .ready_o (in_ready),
    .req_i   (req_i),
    .valid_o (idx_valid),
    .ready_i (idx_ready),
    .ctl_o   (idx_ctl),
    .idx_o   (idx),
    .frac_o  (frac)
  );

  gelu_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (idx_valid),
    .ready_o (idx_ready),
    .ctl_i   (idx_ctl),
    .idx_i   (idx),
    .frac_i  (frac),
    .valid_o (ip_valid),
    .ready_i (ip_ready),
    .ctl_o   (ip_ctl),
    .phi_o   (phi)
  );

  gelu_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ip_valid),
    .ready_o (ip_ready),
    .ctl_i   (ip_ctl),
    .phi_i   (phi),
    .valid_o (valid_o),
    .ready_i (!stall_i),
    .rsp_o   (rsp_o)
  );

endmodule

/* sv/gelu_index.sv */
module gelu_index (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  gelu_pkg::gelu_req_t      req_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output gelu_pkg::gelu_ctl_t      ctl_o,
  output logic [gelu_pkg::IdxW-1:0]  idx_o,
  output logic [gelu_pkg::FracW-1:0] frac_o
);

  logic                        v_q;
  logic                        en;
  gelu_pkg::gelu_ctl_t         ctl_d, ctl_q;
  logic [gelu_pkg::IdxW-1:0]   idx_d, idx_q;
  logic [gelu_pkg::FracW-1:0]  frac_d, frac_q;
  logic [15:0]                 off;
  logic [15:0]                 negx;
  logic [gelu_pkg::PosW-1:0]   pos;
  logic [gelu_pkg::IdxW-1:0]   idx_raw;

  assign en = !v_q || ready_i;
  assign ready_o = en;

  always_comb begin
    off = req_i.x_in + 16'd16384;
    negx = 16'd0 - req_i.x_in;
    pos = gelu_pkg::PosW'(off[14:0]) * gelu_pkg::PosW'(gelu_pkg::TableEntries);
    idx_raw = pos[gelu_pkg::PosW-1:gelu_pkg::FracW];
    idx_d = (idx_raw >= gelu_pkg::IdxW'(gelu_pkg::TableEntries)) ?
            gelu_pkg::IdxW'(gelu_pkg::TableEntries - 1) : idx_raw;
    frac_d = pos[gelu_pkg::FracW-1:0];
    ctl_d.x = req_i.x_in;
    ctl_d.last = req_i.last_in;
    ctl_d.neg = req_i.x_in[15];
    ctl_d.mag = req_i.x_in[15] ? negx[gelu_pkg::MagW-1:0] : req_i.x_in[gelu_pkg::MagW-1:0];
    if (req_i.x_in >= gelu_pkg::XHigh) begin
      ctl_d.cls = gelu_pkg::ClsPass;
    end else if (req_i.x_in < gelu_pkg::XLow) begin
      ctl_d.cls = gelu_pkg::ClsZero;
    end else begin
      ctl_d.cls = gelu_pkg::ClsTable;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      ctl_q <= ctl_d;
      idx_q <= idx_d;
      frac_q <= frac_d;
    end
  end

  assign valid_o = v_q;
  assign ctl_o = ctl_q;
  assign idx_o = idx_q;
  assign frac_o = frac_q;

endmodule

/* sv/gelu_interp.sv */
module gelu_interp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  gelu_pkg::gelu_ctl_t        ctl_i,
  input  logic [gelu_pkg::IdxW-1:0]  idx_i,
  input  logic [gelu_pkg::FracW-1:0] frac_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output gelu_pkg::gelu_ctl_t        ctl_o,
  output logic [gelu_pkg::PhW-1:0]   phi_o
);

  logic                        vb_q, vc_q;
  logic                        en_b, en_c;
  logic [gelu_pkg::IdxW-1:0]   idx_nx;
  logic [gelu_pkg::RomW-1:0]   r0_d, r1_d, r0_q, r1_q;
  logic [gelu_pkg::FracW-1:0]  frac_q;
  logic [gelu_pkg::FracW:0]    wgt0;
  logic [gelu_pkg::PhW-1:0]    phi_d, phi_q;
  gelu_pkg::gelu_ctl_t         ctl_b_q, ctl_c_q;

  assign en_c = !vc_q || ready_i;
  assign en_b = !vb_q || en_c;
  assign ready_o = en_b;

  always_comb begin
    idx_nx = idx_i + 1'b1;
    r0_d = gelu_pkg::PhiRom[gelu_pkg::RomW*idx_i +: gelu_pkg::RomW];
    r1_d = gelu_pkg::PhiRom[gelu_pkg::RomW*idx_nx +: gelu_pkg::RomW];
    wgt0 = (gelu_pkg::FracW+1)'(1 << gelu_pkg::FracW) - {1'b0, frac_q};
    phi_d = gelu_pkg::PhW'(r0_q) * gelu_pkg::PhW'(wgt0)
          + gelu_pkg::PhW'(r1_q) * gelu_pkg::PhW'(frac_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_b) begin
        vb_q <= valid_i;
      end
      if (en_c) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b && valid_i) begin
      r0_q <= r0_d;
      r1_q <= r1_d;
      frac_q <= frac_i;
      ctl_b_q <= ctl_i;
    end
    if (en_c && vb_q) begin
      phi_q <= phi_d;
      ctl_c_q <= ctl_b_q;
    end
  end

  assign valid_o = vc_q;
  assign ctl_o = ctl_c_q;
  assign phi_o = phi_q;

endmodule

/* sv/gelu_scale.sv */
module gelu_scale (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  gelu_pkg::gelu_ctl_t      ctl_i,
  input  logic [gelu_pkg::PhW-1:0] phi_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output gelu_pkg::gelu_rsp_t      rsp_o
);

  logic                          vd_q, ve_q;
  logic                          en_d, en_e;
  logic [gelu_pkg::ProdW-1:0]    prod_d, prod_q;
  logic [gelu_pkg::ProdW-1:0]    rnd;
  logic [15:0]                   mag_r;
  gelu_pkg::gelu_ctl_t           ctl_d_q;
  gelu_pkg::gelu_rsp_t           rsp_d, rsp_q;

  assign en_e = !ve_q || ready_i;
  assign en_d = !vd_q || en_e;
  assign ready_o = en_d;

  always_comb begin
    prod_d = gelu_pkg::ProdW'(ctl_i.mag) * gelu_pkg::ProdW'(phi_i);
    rnd = prod_q + (gelu_pkg::ProdW'(1) << (gelu_pkg::RndPos - 1));
    mag_r = rnd[gelu_pkg::RndPos +: 16];
    rsp_d.last_out = ctl_d_q.last;
    case (ctl_d_q.cls)
      gelu_pkg::ClsPass: rsp_d.y_out = ctl_d_q.x;
      gelu_pkg::ClsZero: rsp_d.y_out = '0;
      gelu_pkg::ClsTable: rsp_d.y_out = ctl_d_q.neg ? 16'd0 - mag_r : mag_r;
      default: rsp_d.y_out = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (en_d) begin
        vd_q <= valid_i;
      end
      if (en_e) begin
        ve_q <= vd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d && valid_i) begin
      prod_q <= prod_d;
      ctl_d_q <= ctl_i;
    end
    if (en_e && vd_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = ve_q;
  assign rsp_o = rsp_q;

  a_zero_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_q && en_e && ctl_d_q.cls == gelu_pkg::ClsZero |=> rsp_q.y_out == 16'd0)
    else $error("negative overflow region must give zero");

  a_pass_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_q && en_e && ctl_d_q.cls == gelu_pkg::ClsPass |=> rsp_q.y_out == $past(ctl_d_q.x))
    else $error("saturated region must pass input through");

  a_sign_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_q && en_e && ctl_d_q.cls == gelu_pkg::ClsTable && !ctl_d_q.neg |=> !rsp_q.y_out[15])
    else $error("nonnegative input gave negative result");

endmodule
